/* rtl/core/box_overlap_dedup_assert.svh */
// Assertion macros shared by the box de-duplication RTL.
`ifndef BOX_OVERLAP_DEDUP_ASSERT_SVH
`define BOX_OVERLAP_DEDUP_ASSERT_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define BOD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define BOD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bod_pkg.sv */
// Package for the box de-duplication block: constants, sequencer states, helpers.
package bod_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_KEPT_DEF   = 32;
  localparam int unsigned COORD_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned SLOT_W  = 5;
  localparam int unsigned TOTAL_W = 6;

  // Threshold register value after reset
  localparam logic [PCT_W-1:0] PCT_RESET = 7'd70;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AREA,
    ST_RD,
    ST_EDGE,
    ST_ISECT,
    ST_MUL_I,
    ST_MUL_B,
    ST_UNION,
    ST_SCALE,
    ST_CMP,
    ST_DONE
  } bod_state_t;

  // Address width of a store with the given depth (at least one bit)
  function automatic int unsigned addr_w(input int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

/* rtl/core/bod_if.sv */
// Request channel interfaces: box input and de-duplication result.
interface bod_in_if #(
  parameter int unsigned COORD_BITS = bod_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] box_x;
  logic [COORD_BITS-1:0] box_y;
  logic [COORD_BITS-1:0] box_w;
  logic [COORD_BITS-1:0] box_h;
  logic                  frame_end;

  modport source (output valid, box_x, box_y, box_w, box_h, frame_end, input ready);
  modport sink   (input valid, box_x, box_y, box_w, box_h, frame_end, output ready);
endinterface

interface bod_out_if;
  logic                         valid;
  logic                         ready;
  logic                         is_duplicate;
  logic [bod_pkg::SLOT_W-1:0]   match_slot;
  logic [bod_pkg::TOTAL_W-1:0]  kept_total;
  logic                         overflow;

  modport source (output valid, is_duplicate, match_slot, kept_total, overflow,
                  input ready);
  modport sink   (input valid, is_duplicate, match_slot, kept_total, overflow,
                  output ready);
endinterface

/* rtl/core/bod_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bod_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [bod_pkg::addr_w(DEPTH)-1:0]      waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [bod_pkg::addr_w(DEPTH)-1:0]      raddr,
  output logic [WIDTH-1:0]                       rdata
);
  import bod_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/box_overlap_dedup.sv */
// Box de-duplication top: compares each box with the frame's kept set.
// With an empty set a box goes straight to a result; else it is compared with each
// kept box in turn through the one shared multiplier, stopping early on a match.
// The input waits while a box is compared; a result waits in an output register,
// so the next box is taken before it drains.
// Reset (rst_n low, synchronous): kept set empty, threshold 70 percent, channels idle.
`include "box_overlap_dedup_assert.svh"

module box_overlap_dedup #(
  parameter int unsigned MAX_KEPT   = bod_pkg::MAX_KEPT_DEF,
  parameter int unsigned COORD_BITS = bod_pkg::COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bod_pkg::PCT_W-1:0]  cfg_wdata,
  bod_in_if.sink                     in_chan,
  bod_out_if.source                  out_chan
);
  import bod_pkg::*;

  localparam int unsigned CB     = COORD_BITS;
  localparam int unsigned EW     = CB + 1;
  localparam int unsigned AREA_W = 2 * CB;
  localparam int unsigned UN_W   = 2 * CB + 1;
  localparam int unsigned HIN_W  = 2 * CB + 7;
  localparam int unsigned SCL_W  = UN_W + PCT_W;
  localparam int unsigned AW     = addr_w(MAX_KEPT);
  localparam int unsigned CW     = $clog2(MAX_KEPT + 1);
  localparam int unsigned BOX_W  = 4 * CB;

  bod_state_t state_r, state_nxt;

  logic [PCT_W-1:0]  pct_r;
  logic [CB-1:0]     ax_r, ay_r, aw_r, ah_r;
  logic              fe_r;
  logic [CW-1:0]     count_r;
  logic [AW-1:0]     idx_r;
  logic              dup_r;

  logic [CB-1:0]     left_r, top_r;
  logic [EW-1:0]     right_r, bottom_r;
  logic [CB-1:0]     iw_r, ih_r;
  logic [AREA_W-1:0] aarea_r, barea_r, in_r;
  logic [UN_W-1:0]   un_r;
  logic [HIN_W-1:0]  hin_r;
  logic [SCL_W-1:0]  pscl_r;

  logic              out_valid_r, out_dup_r, out_ovf_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [TOTAL_W-1:0] out_total_r;

  // Kept-box store, entry layout {h, w, y, x}
  logic [BOX_W-1:0]  rdata;
  logic              ram_we;
  logic [CB-1:0]     bx, by, bw, bh;

  bod_ram #(
    .WIDTH (BOX_W),
    .DEPTH (MAX_KEPT)
  ) u_kept (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({ah_r, aw_r, ay_r, ax_r}),
    .raddr (idx_r),
    .rdata (rdata)
  );

  assign bx = rdata[CB-1:0];
  assign by = rdata[2*CB-1:CB];
  assign bw = rdata[3*CB-1:2*CB];
  assign bh = rdata[4*CB-1:3*CB];

  // Handshake terms
  logic in_fire, out_load;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_load      = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  // Shared multiplier: box area, intersection area, kept-box area
  logic [CB-1:0]     mul_a, mul_b;
  logic [AREA_W-1:0] mul_p;
  always_comb begin
    case (state_r)
      ST_AREA:  begin mul_a = aw_r; mul_b = ah_r; end
      ST_MUL_I: begin mul_a = iw_r; mul_b = ih_r; end
      default:  begin mul_a = bw;   mul_b = bh;   end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Right and bottom edges of the new box and the kept box
  logic [EW-1:0] a_right, a_bottom, b_right, b_bottom;
  assign a_right  = EW'(ax_r) + EW'(aw_r);
  assign a_bottom = EW'(ay_r) + EW'(ah_r);
  assign b_right  = EW'(bx) + EW'(bw);
  assign b_bottom = EW'(by) + EW'(bh);

  // Intersection rectangle and containment test
  logic          empty;
  logic [CB-1:0] ix, iy, iw, ih;
  logic          contain;
  assign empty = (right_r <= EW'(left_r)) || (bottom_r <= EW'(top_r));
  assign ix    = empty ? '0 : left_r;
  assign iy    = empty ? '0 : top_r;
  assign iw    = empty ? '0 : CB'(right_r - EW'(left_r));
  assign ih    = empty ? '0 : CB'(bottom_r - EW'(top_r));
  assign contain = (ix == ax_r && iy == ay_r && iw == aw_r && ih == ah_r) ||
                   (ix == bx   && iy == by   && iw == bw   && ih == bh);

  // Union, scaled intersection, threshold product
  logic [UN_W-1:0]  un;
  logic [HIN_W-1:0] hin;
  logic [SCL_W-1:0] scl_prod;
  logic             over;
  assign un       = UN_W'(aarea_r) + UN_W'(barea_r) - UN_W'(in_r);
  assign hin      = (HIN_W'(in_r) << 6) + (HIN_W'(in_r) << 5) + (HIN_W'(in_r) << 2);
  assign scl_prod = un_r * pct_r;
  assign over     = SCL_W'(hin_r) > pscl_r;

  // Loop and store status
  logic last, full, store;
  logic [CW-1:0] total;
  assign last  = (CW'(idx_r) + CW'(1)) == count_r;
  assign full  = (count_r == CW'(MAX_KEPT));
  assign store = !dup_r && !full;
  assign total = store ? count_r + CW'(1) : count_r;
  assign ram_we = out_load && store;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_AREA;
      ST_AREA:  state_nxt = (count_r == '0) ? ST_DONE : ST_EDGE;
      ST_RD:    state_nxt = ST_EDGE;
      ST_EDGE:  state_nxt = ST_ISECT;
      ST_ISECT: state_nxt = contain ? ST_DONE : ST_MUL_I;
      ST_MUL_I: state_nxt = ST_MUL_B;
      ST_MUL_B: state_nxt = ST_UNION;
      ST_UNION: begin
        if (un != '0) begin
          state_nxt = ST_SCALE;
        end else begin
          state_nxt = last ? ST_DONE : ST_RD;
        end
      end
      ST_SCALE: state_nxt = ST_CMP;
      ST_CMP:   state_nxt = (over || last) ? ST_DONE : ST_RD;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control registers: threshold, kept count, slot index, match flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r   <= PCT_RESET;
      count_r <= '0;
      idx_r   <= '0;
      dup_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        pct_r <= cfg_wdata;
      end
      if (in_fire) begin
        idx_r <= '0;
        dup_r <= 1'b0;
      end
      if ((state_r == ST_ISECT && contain) || (state_r == ST_CMP && over)) begin
        dup_r <= 1'b1;
      end
      if ((state_r == ST_CMP && !over && !last) ||
          (state_r == ST_UNION && un == '0 && !last)) begin
        idx_r <= idx_r + AW'(1);
      end
      if (out_load) begin
        count_r <= fe_r ? '0 : total;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ax_r <= in_chan.box_x;
      ay_r <= in_chan.box_y;
      aw_r <= in_chan.box_w;
      ah_r <= in_chan.box_h;
      fe_r <= in_chan.frame_end;
    end
    case (state_r)
      ST_AREA:  aarea_r <= mul_p;
      ST_EDGE: begin
        left_r   <= (ax_r > bx) ? ax_r : bx;
        top_r    <= (ay_r > by) ? ay_r : by;
        right_r  <= (a_right < b_right) ? a_right : b_right;
        bottom_r <= (a_bottom < b_bottom) ? a_bottom : b_bottom;
      end
      ST_ISECT: begin
        iw_r <= iw;
        ih_r <= ih;
      end
      ST_MUL_I: in_r    <= mul_p;
      ST_MUL_B: barea_r <= mul_p;
      ST_UNION: begin
        un_r  <= un;
        hin_r <= hin;
      end
      ST_SCALE: pscl_r <= scl_prod;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_dup_r   <= dup_r;
      out_slot_r  <= dup_r ? SLOT_W'(idx_r) : '0;
      out_total_r <= TOTAL_W'(total);
      out_ovf_r   <= !dup_r && full;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.is_duplicate = out_dup_r;
  assign out_chan.match_slot   = out_slot_r;
  assign out_chan.kept_total   = out_total_r;
  assign out_chan.overflow     = out_ovf_r;

  // Checks
  `BOD_ASSERT_NEXT(a_busy_after_take, in_fire, !in_chan.ready, "ready high while busy")
  `BOD_ASSERT_NOW(a_dup_xor_ovf, out_chan.valid, !(out_chan.is_duplicate && out_chan.overflow), "duplicate and overflow together")
  `BOD_ASSERT_NOW(a_ovf_full, out_chan.valid && out_chan.overflow, out_chan.kept_total == TOTAL_W'(MAX_KEPT), "overflow below full store")
  `BOD_ASSERT_NOW(a_idx_in_set, state_r == ST_EDGE, CW'(idx_r) < count_r, "compare beyond kept set")

endmodule
